[src/otp_token_verifier_defines.svh]
// ----------------------------------------------------------------------------
// otp token verifier assertion macros
// concurrent assertion helpers, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef OTP_TOKEN_VERIFIER_DEFINES_SVH
`define OTP_TOKEN_VERIFIER_DEFINES_SVH

`ifndef SYNTHESIS

// property holds at every clock edge outside reset
`define OTV_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("otv assertion failed");

// antecedent implies consequent in the same cycle
`define OTV_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("otv assertion failed");

// antecedent implies consequent in the next cycle
`define OTV_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("otv assertion failed");

`else

`define OTV_ASSERT(name, clk, rst_n, prop)
`define OTV_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define OTV_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

[src/otv_pkg.sv]
// ----------------------------------------------------------------------------
// otv_pkg
// shared types and constants of the one-time-password token verifier
// ----------------------------------------------------------------------------
package otv_pkg;

  localparam int unsigned TOKEN_W        = 20;
  localparam int unsigned SLOT_W         = 8;
  localparam int unsigned STRIKE_W       = 3;
  localparam int unsigned LCG_BITS       = 15;
  localparam int unsigned LCG_LOW        = 31;
  localparam int unsigned USER_SLOTS_DEF = 256;
  localparam int unsigned CFG_ADDR_W     = 3;
  localparam int unsigned CFG_DATA_W     = 32;

  localparam logic [LCG_LOW-1:0]  LCG_MUL = 31'd1103515245;
  localparam logic [LCG_LOW-1:0]  LCG_INC = 31'd12345;
  localparam logic [TOKEN_W-1:0]  SALT_RESET = 20'd135790;
  localparam logic [STRIKE_W-1:0] STRIKE_LIMIT_RESET = 3'd3;
  localparam logic [STRIKE_W-1:0] STRIKE_MAX = 3'd7;

  // register index, taken from paddr[2]
  localparam logic REG_SALT         = 1'b0;
  localparam logic REG_STRIKE_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    REQ_ENROLL   = 2'd0,
    REQ_VALIDATE = 2'd1,
    REQ_PAD      = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_BAD_TOKEN = 2'd1,
    STS_NOT_REG   = 2'd2,
    STS_LOCKED    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_MUL   = 4'b0100,
    ST_EVAL  = 4'b1000
  } state_e;

  // finish an lcg step from the kept product bits
  function automatic logic [TOKEN_W-1:0] lcg_finish(
    input logic [LCG_BITS-1:0] bits,
    input logic [TOKEN_W-1:0]  uid,
    input logic [TOKEN_W-1:0]  salt
  );
    lcg_finish = {{(TOKEN_W-LCG_BITS){1'b0}}, bits} ^ uid ^ salt;
  endfunction

endpackage

[src/otp_token_verifier.sv]
// ----------------------------------------------------------------------------
// otp_token_verifier
// lcg based one-time-password verifier with a per-slot token table
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The table read happens
// on the accepting edge. The lcg multiply (ST_MUL) and then the evaluate and
// write back (ST_EVAL) follow, and busy is high during both. The single result
// is on status_o and value_o, flagged by done_o for one cycle. That is the first
// cycle in which busy is low again. The receiver cannot stall the result, so
// sample it when done_o is high. The next request may be issued in that same
// cycle; a new request is not taken before the last one is through. After reset
// the block clears the registered flag of every table slot, one slot a cycle,
// and stays busy until the last slot is cleared.
// Configuration writes are taken during that time.
// Configuration: salt at byte address 0, strike limit at byte address 4.
`include "otp_token_verifier_defines.svh"

module otp_token_verifier #(
  parameter int unsigned USER_SLOTS = otv_pkg::USER_SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request side
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      req_type_i,
  input  logic [otv_pkg::SLOT_W-1:0]      user_slot_i,
  input  logic [otv_pkg::TOKEN_W-1:0]     user_id_i,
  input  logic [otv_pkg::TOKEN_W-1:0]     token_i,
  // result side
  output logic                            done_o,
  output logic [1:0]                      status_o,
  output logic [otv_pkg::TOKEN_W-1:0]     value_o,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [otv_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [otv_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [otv_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  import otv_pkg::*;

  localparam int unsigned AW = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1;
  localparam int unsigned MW = TOKEN_W + 1;

  // configuration registers
  logic [TOKEN_W-1:0]  salt_q;
  logic [STRIKE_W-1:0] strike_limit_q;
  logic                cfg_wr;

  // control state
  state_e              state_q, state_d;
  logic [AW-1:0]       clr_cnt_q;
  logic [STRIKE_W-1:0] strike_count_q;
  logic                locked_q;

  // request registers
  logic [1:0]          req_q;
  logic                in_range_q;
  logic [AW-1:0]       addr_q;
  logic [TOKEN_W-1:0]  uid_q;
  logic [TOKEN_W-1:0]  tok_q;

  // token table: registered flag on top of the last token
  logic [MW-1:0]       mem_q [USER_SLOTS];
  logic [MW-1:0]       rd_q;
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic [MW-1:0]       mem_wd;

  // datapath
  logic [TOKEN_W-1:0]  mul_op;
  logic [50:0]         mul_full;
  logic [LCG_LOW-1:0]  mul_sum;
  logic [LCG_BITS-1:0] prod_q;
  logic [TOKEN_W-1:0]  lcg_val;
  logic [STRIKE_W-1:0] strike_inc;

  logic                accept;
  logic [AW+SLOT_W-1:0] slot_ext;
  logic [AW-1:0]       in_addr;
  logic                in_range;

  // result registers
  logic                done_q;
  logic [1:0]          status_q, status_d;
  logic [TOKEN_W-1:0]  value_q, value_d;
  logic                wb_en;
  logic [STRIKE_W-1:0] strike_count_d;
  logic                locked_d;

  // -------------------------------------------------------------------------
  // configuration port
  // -------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      salt_q         <= SALT_RESET;
      strike_limit_q <= STRIKE_LIMIT_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_SALT:         salt_q         <= pwdata[TOKEN_W-1:0];
        REG_STRIKE_LIMIT: strike_limit_q <= pwdata[STRIKE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SALT:         prdata = {{(CFG_DATA_W-TOKEN_W){1'b0}}, salt_q};
      REG_STRIKE_LIMIT: prdata = {{(CFG_DATA_W-STRIKE_W){1'b0}}, strike_limit_q};
      default:          prdata = '0;
    endcase
  end

  // -------------------------------------------------------------------------
  // request capture
  // -------------------------------------------------------------------------
  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign slot_ext = {{AW{1'b0}}, user_slot_i};
  assign in_addr  = slot_ext[AW-1:0];
  assign in_range = (32'(user_slot_i) < 32'(USER_SLOTS));

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q      <= req_type_i;
      in_range_q <= in_range;
      addr_q     <= in_addr;
      uid_q      <= user_id_i;
      tok_q      <= token_i;
    end
  end

  // -------------------------------------------------------------------------
  // token table
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (accept) begin
      rd_q <= mem_q[in_addr];
    end
  end

  // clearing pass writes the flag low, evaluate writes back the new token
  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_q;
    mem_wd = {1'b1, lcg_val};
    if (state_q == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt_q;
      mem_wd = '0;
    end else if (wb_en) begin
      mem_we = 1'b1;
    end
  end

  // -------------------------------------------------------------------------
  // lcg multiply
  // -------------------------------------------------------------------------
  always_comb begin
    case (req_q)
      REQ_ENROLL:   mul_op = uid_q;
      REQ_VALIDATE: mul_op = rd_q[TOKEN_W-1:0];
      default:      mul_op = tok_q;
    endcase
  end

  assign mul_full = 51'(mul_op) * 51'(LCG_MUL);
  assign mul_sum  = mul_full[LCG_LOW-1:0] + LCG_INC;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      prod_q <= mul_sum[LCG_LOW-1:LCG_LOW-LCG_BITS];
    end
  end

  assign lcg_val = lcg_finish(prod_q, uid_q, salt_q);

  // -------------------------------------------------------------------------
  // evaluate
  // -------------------------------------------------------------------------
  assign strike_inc = (strike_count_q < STRIKE_MAX) ? strike_count_q + 3'd1
                                                    : strike_count_q;

  always_comb begin
    status_d       = STS_OK;
    value_d        = '0;
    wb_en          = 1'b0;
    strike_count_d = strike_count_q;
    locked_d       = locked_q;
    if (locked_q) begin
      status_d = STS_LOCKED;
    end else begin
      case (req_q)
        REQ_ENROLL: begin
          if (in_range_q) begin
            wb_en = 1'b1;
          end else begin
            status_d = STS_NOT_REG;
          end
        end
        REQ_VALIDATE: begin
          if (!in_range_q || !rd_q[MW-1]) begin
            status_d = STS_NOT_REG;
          end else if (tok_q == lcg_val) begin
            wb_en          = 1'b1;
            strike_count_d = '0;
          end else begin
            strike_count_d = strike_inc;
            if (strike_inc >= strike_limit_q) begin
              locked_d = 1'b1;
              status_d = STS_LOCKED;
            end else begin
              status_d = STS_BAD_TOKEN;
            end
          end
        end
        REQ_PAD: value_d = lcg_val;
        default: ;
      endcase
    end
    if (state_q != ST_EVAL) begin
      wb_en          = 1'b0;
      strike_count_d = strike_count_q;
      locked_d       = locked_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EVAL) begin
      status_q <= status_d;
      value_q  <= value_d;
    end
  end

  assign done_o   = done_q;
  assign status_o = status_q;
  assign value_o  = value_q;

  // -------------------------------------------------------------------------
  // sequencer
  // -------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_cnt_q == AW'(USER_SLOTS - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (accept) state_d = ST_MUL;
      ST_MUL:   state_d = ST_EVAL;
      ST_EVAL:  state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_cnt_q      <= '0;
      strike_count_q <= '0;
      locked_q       <= 1'b0;
      done_q         <= 1'b0;
    end else begin
      state_q        <= state_d;
      strike_count_q <= strike_count_d;
      locked_q       <= locked_d;
      done_q         <= (state_q == ST_EVAL);
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
    end
  end

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
  `OTV_ASSERT_IMPL(a_done_after_eval, clk_i, rst_ni, done_q, $past(state_q == ST_EVAL))
  `OTV_ASSERT_NEXT(a_lock_sticks, clk_i, rst_ni, locked_q, locked_q)
  `OTV_ASSERT_IMPL(a_locked_answers, clk_i, rst_ni, done_q && $past(locked_q),
                   status_o == STS_LOCKED)
  `OTV_ASSERT_IMPL(a_value_only_ok, clk_i, rst_ni, done_q && status_o != STS_OK,
                   value_o == '0)
  `OTV_ASSERT_IMPL(a_no_table_write_idle, clk_i, rst_ni, state_q == ST_IDLE, !mem_we)

endmodule
